[design/ihexw_pkg.sv]
// ----------------------------------------------------------------------------
// ihexw_pkg
// Types, constants and helpers shared by the hex record writer files.
// ----------------------------------------------------------------------------
package ihexw_pkg;

    localparam int MaxRecordBytes = 16;
    localparam int CountW         = 5;

    localparam logic [7:0] CharColon = 8'h3A;
    localparam logic [7:0] CharLf    = 8'd10;
    localparam logic [7:0] CharZero  = 8'd48;
    localparam logic [7:0] HexAlphaBase = 8'd55;
    localparam logic [3:0] HexNineDigit = 4'd9;

    typedef struct packed {
        logic [15:0] load_address;
        logic [7:0]  data_byte;
        logic        last_byte;
    } t_in_req;

    typedef struct packed {
        logic [7:0] ascii_char;
        logic       end_of_line;
    } t_out_req;

    // uppercase ascii hex digit of one nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] ext;
        ext = {4'b0000, v};
        if (v <= HexNineDigit) begin
            return CharZero + ext;
        end else begin
            return HexAlphaBase + ext;
        end
    endfunction

endpackage

[design/ihexw_ram.sv]
// ----------------------------------------------------------------------------
// ihexw_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ihexw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/intel_hex_record_writer_unit.sv]
// ----------------------------------------------------------------------------
// intel_hex_record_writer_unit
// Buffers data bytes and writes each closed record as one ascii hex line.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid/o_in_stall   t_in_req  i_in_req
//   out      output     o_out_valid/i_out_stall t_out_req o_out_req
//
// A record of n bytes is written out as a line of 12 + 2n characters.
// Bytes are written to a 16 entry buffer RAM; the line is built by reading
// it back one entry per two characters through its registered read port.
// Input is stalled while a line is emitted, until the LF is in the output
// register. Output stalls freeze the character sequencer.
// Reset is synchronous, active low; the buffer RAM is not cleared.
// ----------------------------------------------------------------------------
module intel_hex_record_writer_unit
    import ihexw_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = MaxRecordBytes
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_req o_out_req
);

    localparam int AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
    localparam logic [CountW-1:0] MaxCount = CountW'(MAX_RECORD_BYTES);
    localparam logic [3:0] HeadLast = 4'd8;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_HEAD,
        S_DATA,
        S_CHK,
        S_EOL
    } t_state;

    t_state            r_state, n_state;
    logic [CountW-1:0] r_count, n_count;
    logic [CountW-1:0] r_len, n_len;
    logic [CountW-1:0] r_rd_idx, n_rd_idx;
    logic [15:0]       r_addr, n_addr;
    logic [7:0]        r_sum, n_sum;
    logic [7:0]        r_chk, n_chk;
    logic [3:0]        r_hidx, n_hidx;
    logic [3:0]        r_lo, n_lo;
    logic              r_nib, n_nib;
    logic              r_out_valid, n_out_valid;
    t_out_req          r_out, n_out;

    logic              accept;
    logic              adv;
    logic [7:0]        base_sum;
    logic [7:0]        sum_new;
    logic [CountW-1:0] cnt_new;
    logic              close;
    logic [7:0]        len_byte;
    logic [7:0]        head_char;
    logic [7:0]        rd_data;

    ihexw_ram #(
        .WIDTH (8),
        .DEPTH (MAX_RECORD_BYTES),
        .AW    (AW)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in_req.data_byte),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    assign o_in_stall = (r_state != S_COLLECT);
    assign accept     = i_in_valid && !o_in_stall;
    assign adv        = !r_out_valid || !i_out_stall;

    // address bytes enter the sum with the first byte of a record
    assign base_sum = (r_count == '0)
                    ? i_in_req.load_address[15:8] + i_in_req.load_address[7:0]
                    : r_sum;
    assign sum_new  = base_sum + i_in_req.data_byte;
    assign cnt_new  = r_count + CountW'(1);
    assign close    = i_in_req.last_byte || (cnt_new >= MaxCount);
    assign len_byte = {{(8 - CountW){1'b0}}, r_len};

    always_comb begin
        case (r_hidx)
            4'd0:    head_char = CharColon;
            4'd1:    head_char = hex_digit(len_byte[7:4]);
            4'd2:    head_char = hex_digit(len_byte[3:0]);
            4'd3:    head_char = hex_digit(r_addr[15:12]);
            4'd4:    head_char = hex_digit(r_addr[11:8]);
            4'd5:    head_char = hex_digit(r_addr[7:4]);
            4'd6:    head_char = hex_digit(r_addr[3:0]);
            default: head_char = CharZero;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_len       = r_len;
        n_rd_idx    = r_rd_idx;
        n_addr      = r_addr;
        n_sum       = r_sum;
        n_chk       = r_chk;
        n_hidx      = r_hidx;
        n_lo        = r_lo;
        n_nib       = r_nib;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_COLLECT: begin
                if (accept) begin
                    if (r_count == '0) begin
                        n_addr = i_in_req.load_address;
                    end
                    if (close) begin
                        n_len    = cnt_new;
                        n_chk    = 8'd0 - (sum_new + {{(8 - CountW){1'b0}}, cnt_new});
                        n_count  = '0;
                        n_sum    = 8'd0;
                        n_hidx   = 4'd0;
                        n_rd_idx = '0;
                        n_state  = S_HEAD;
                    end else begin
                        n_count = cnt_new;
                        n_sum   = sum_new;
                    end
                end
            end
            S_HEAD: begin
                if (adv) begin
                    n_out_valid       = 1'b1;
                    n_out.ascii_char  = head_char;
                    n_out.end_of_line = 1'b0;
                    n_hidx            = r_hidx + 4'd1;
                    if (r_hidx == HeadLast) begin
                        n_nib   = 1'b0;
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                // the read index moves on the high digit so the next entry
                // has settled in the read register before its high digit is built
                if (adv) begin
                    n_out_valid       = 1'b1;
                    n_out.end_of_line = 1'b0;
                    if (!r_nib) begin
                        n_out.ascii_char = hex_digit(rd_data[7:4]);
                        n_lo             = rd_data[3:0];
                        n_rd_idx         = r_rd_idx + CountW'(1);
                        n_nib            = 1'b1;
                    end else begin
                        n_out.ascii_char = hex_digit(r_lo);
                        n_nib            = 1'b0;
                        if (r_rd_idx == r_len) begin
                            n_state = S_CHK;
                        end
                    end
                end
            end
            S_CHK: begin
                if (adv) begin
                    n_out_valid       = 1'b1;
                    n_out.end_of_line = 1'b0;
                    if (!r_nib) begin
                        n_out.ascii_char = hex_digit(r_chk[7:4]);
                        n_nib            = 1'b1;
                    end else begin
                        n_out.ascii_char = hex_digit(r_chk[3:0]);
                        n_nib            = 1'b0;
                        n_state          = S_EOL;
                    end
                end
            end
            S_EOL: begin
                if (adv) begin
                    n_out_valid       = 1'b1;
                    n_out.ascii_char  = CharLf;
                    n_out.end_of_line = 1'b1;
                    n_state           = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_count     <= '0;
            r_sum       <= 8'd0;
            r_addr      <= 16'd0;
            r_len       <= '0;
            r_rd_idx    <= '0;
            r_hidx      <= 4'd0;
            r_nib       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_addr      <= n_addr;
            r_len       <= n_len;
            r_rd_idx    <= n_rd_idx;
            r_hidx      <= n_hidx;
            r_nib       <= n_nib;
            r_out_valid <= n_out_valid;
        end
        r_chk <= n_chk;
        r_lo  <= n_lo;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // end of line flag only ever rides on the LF character
    a_eol_is_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.end_of_line |-> o_out_req.ascii_char == CharLf)
        else $error("end_of_line on a character other than LF");

    // the open record never holds a full buffer
    a_count_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < MaxCount)
        else $error("byte count reached the record cap without closing");

    // a record being written out has between one and the cap bytes
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_COLLECT |-> r_len != '0 && r_len <= MaxCount)
        else $error("record length out of range during emission");

    // reads never run past the record
    a_rd_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DATA |-> r_rd_idx <= r_len)
        else $error("buffer read index beyond record length");

    // the first header step, once it advances, puts a colon out next
    a_colon_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HEAD && r_hidx == 4'd0 && adv |=>
            o_out_valid && o_out_req.ascii_char == CharColon)
        else $error("record line does not open with a colon");

endmodule
